// File: src/jsle_pkg.sv
package jsle_pkg;

    localparam int MAX_OUT = 9;
    localparam int CNT_W   = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_8      = 8'h38;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] LEAD_E2   = 8'hE2;
    localparam logic [7:0] MID_80    = 8'h80;
    localparam logic [7:0] TAIL_A8   = 8'hA8;
    localparam logic [7:0] TAIL_A9   = 8'hA9;
    localparam logic [7:0] CTRL_TOP  = 8'h20;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_E2   = 2'd1;
    localparam logic [1:0] HELD_E280 = 2'd2;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] chars;
        logic [CNT_W-1:0]        count;
        logic                    closes;
        logic [1:0]              held_next;
        logic                    open_next;
    } step_result_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
            d = CH_0 + {4'd0, nib};
        else
            d = 8'h41 + {4'd0, nib - 4'd10};
        return d;
    endfunction

endpackage

// File: src/jsle_step.sv
module jsle_step
    import jsle_pkg::*;
(
    input  logic [7:0]   data_byte,
    input  logic         has_byte,
    input  logic         end_of_string,
    input  logic [1:0]   held_count,
    input  logic         literal_open,
    output step_result_t result
);

    logic [MAX_OUT-1:0][7:0] chars;
    logic [CNT_W-1:0]        n;
    logic [1:0]              held;
    logic                    fresh;
    logic                    open_q;

    always_comb
    begin
        chars  = '0;
        n      = '0;
        held   = (held_count == 2'd3) ? HELD_NONE : held_count;
        fresh  = 1'b0;
        open_q = literal_open;

        if (has_byte || end_of_string)
        begin
            if (!open_q)
            begin
                held = HELD_NONE;
                chars[n[3:0]] = CH_QUOTE;
                n = n + 1'b1;
                open_q = 1'b1;
            end

            if (has_byte)
            begin
                // resolve a pending E2 / E2 80 prefix against this byte
                if (held == HELD_E2)
                begin
                    if (data_byte == MID_80)
                        held = HELD_E280;
                    else
                    begin
                        chars[n] = LEAD_E2;
                        n = n + 1'b1;
                        held = HELD_NONE;
                        fresh = 1'b1;
                    end
                end
                else if (held == HELD_E280)
                begin
                    if (data_byte == TAIL_A8 || data_byte == TAIL_A9)
                    begin
                        chars[n] = CH_BSLASH; n = n + 1'b1;
                        chars[n] = CH_U;      n = n + 1'b1;
                        chars[n] = CH_2;      n = n + 1'b1;
                        chars[n] = CH_0;      n = n + 1'b1;
                        chars[n] = CH_2;      n = n + 1'b1;
                        chars[n] = (data_byte == TAIL_A8) ? CH_8 : CH_9;
                        n = n + 1'b1;
                        held = HELD_NONE;
                    end
                    else
                    begin
                        chars[n] = LEAD_E2; n = n + 1'b1;
                        chars[n] = MID_80;  n = n + 1'b1;
                        held = HELD_NONE;
                        fresh = 1'b1;
                    end
                end
                else
                    fresh = 1'b1;

                if (fresh)
                begin
                    if (data_byte == LEAD_E2)
                        held = HELD_E2;
                    else if (data_byte == CH_QUOTE || data_byte == CH_BSLASH
                             || data_byte == CH_NL || data_byte == CH_CR
                             || data_byte == CH_TAB)
                    begin
                        chars[n] = CH_BSLASH;
                        n = n + 1'b1;
                        case (data_byte)
                            CH_NL:   chars[n] = CH_N;
                            CH_CR:   chars[n] = CH_R;
                            CH_TAB:  chars[n] = CH_T;
                            default: chars[n] = data_byte;
                        endcase
                        n = n + 1'b1;
                    end
                    else if (data_byte < CTRL_TOP)
                    begin
                        chars[n] = CH_BSLASH; n = n + 1'b1;
                        chars[n] = CH_U;      n = n + 1'b1;
                        chars[n] = CH_0;      n = n + 1'b1;
                        chars[n] = CH_0;      n = n + 1'b1;
                        chars[n] = hex_digit(data_byte[7:4]); n = n + 1'b1;
                        chars[n] = hex_digit(data_byte[3:0]); n = n + 1'b1;
                    end
                    else
                    begin
                        chars[n] = data_byte;
                        n = n + 1'b1;
                    end
                end
            end

            if (end_of_string)
            begin
                // flush whatever prefix is still held, then close
                if (held == HELD_E2 || held == HELD_E280)
                begin
                    chars[n] = LEAD_E2;
                    n = n + 1'b1;
                end
                if (held == HELD_E280)
                begin
                    chars[n] = MID_80;
                    n = n + 1'b1;
                end
                chars[n] = CH_QUOTE;
                n = n + 1'b1;
                held = HELD_NONE;
                open_q = 1'b0;
            end
        end

        result.chars     = chars;
        result.count     = n;
        result.closes    = end_of_string;
        result.held_next = held;
        result.open_next = open_q;
    end

endmodule

// File: src/js_string_literal_escaper.sv
// JavaScript string literal escaper.
//
// Input channel (in_valid/in_ready): one item per transfer, carrying
// data_byte, has_byte and end_of_string. An item with has_byte 0 and
// end_of_string 0 is consumed without effect.
// Output channel (out_valid/out_ready): one literal byte per transfer on
// out_char; out_last marks the closing quote.
//
// Each accepted item is escaped combinationally and loaded into a result
// buffer of up to nine bytes, which drains one byte per cycle while
// out_ready is high. The first byte of an item appears in the cycle after
// its transfer. A new item is accepted in the same cycle the last byte of
// the previous one is taken, so plain bytes stream at one per cycle unless
// the receiver stalls; a longer item holds the output until it is drained.
//
// Reset empties the buffer and clears the held E2/E2 80 prefix and the open flag.
// When the receiver stalls, the current byte holds and in_ready drops
// once the buffer cannot be emptied in this cycle.
module js_string_literal_escaper
    import jsle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last
);

    step_result_t            step;
    logic [MAX_OUT-1:0][7:0] chars_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        idx_next;
    logic                    closes_reg;
    logic [1:0]              held_reg;
    logic                    open_reg;
    logic                    at_tail;
    logic                    in_xfer;
    logic                    out_xfer;

    jsle_step u_step (
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .held_count    (held_reg),
        .literal_open  (open_reg),
        .result        (step)
    );

    assign out_valid = idx_reg < count_reg;
    assign at_tail   = (idx_reg == count_reg - 1'b1);
    assign out_char  = chars_reg[idx_reg];
    assign out_last  = closes_reg && at_tail;
    assign out_xfer  = out_valid && out_ready;

    // Accept when the buffer is empty or its final byte leaves now.
    assign in_ready  = !out_valid || (out_ready && at_tail);
    assign in_xfer   = in_valid && in_ready;
    assign idx_next  = idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            closes_reg <= 1'b0;
            held_reg   <= HELD_NONE;
            open_reg   <= 1'b0;
        end
        else if (in_xfer)
        begin
            count_reg  <= step.count;
            idx_reg    <= '0;
            closes_reg <= step.closes;
            held_reg   <= step.held_next;
            open_reg   <= step.open_next;
        end
        else if (out_xfer)
        begin
            idx_reg <= idx_next;
        end
    end

    // Payload buffer: load on transfer, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            chars_reg <= step.chars;
    end

endmodule

// File: test/js_string_literal_escaper_tb.sv
module js_string_literal_escaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsle_pkg::*;

    // Watchdog: cycles in a row with no transfer on either channel.
    localparam int STALL_LIMIT = 1000;
    // Cycles to wait after the last literal byte, for any stray output.
    localparam int TAIL_CYCLES = 12;
    // Random items per idling phase.
    localparam int ITEMS_PER_PHASE = 92;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_string;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_char;
    logic       out_last;

    js_string_literal_escaper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .out_last      (out_last)
    );

    // One byte of the quoted literal as the output channel should carry it.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } lit_byte_t;

    // One row of the directed table. n_typed < 0 means the row is checked
    // against the escaper model; otherwise chars holds n_typed bytes,
    // first byte in the most significant position of the used span.
    typedef struct {
        logic [7:0]  b;
        logic        h;
        logic        e;
        int          n_typed;
        logic [71:0] chars;
    } dir_row_t;

    lit_byte_t  lit_due[$];     // literal bytes still owed by the block
    dir_row_t   dir_tab[$];
    logic [1:0] held_n;         // model: bytes held of a possible E2 80 A8/A9
    logic       str_open;       // model: opening quote already emitted
    int         fail_cnt;
    int         items_done;
    int         quiet_cycles;
    int         snd_idle;       // percent of cycles the sender holds off
    int         rcv_idle;       // percent of cycles the receiver stalls
    lit_byte_t  head;

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Escaper model
    // ------------------------------------------------------------------

    task automatic owe(input logic [7:0] c, input logic last);
        lit_byte_t x;
        x.ch   = c;
        x.last = last;
        lit_due = {lit_due, x};
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return CH_0 + {4'd0, v};
        return 8'h37 + {4'd0, v};
    endfunction

    task automatic owe_u_escape(input logic [7:0] d0, input logic [7:0] d1,
                                input logic [7:0] d2, input logic [7:0] d3);
        owe(CH_BSLASH, 1'b0);
        owe(CH_U, 1'b0);
        owe(d0, 1'b0);
        owe(d1, 1'b0);
        owe(d2, 1'b0);
        owe(d3, 1'b0);
    endtask

    // Handle a byte with nothing held: hold an E2, escape or pass the rest.
    task automatic escape_fresh(input logic [7:0] b);
        if (b == LEAD_E2)
            held_n = HELD_E2;
        else if (b == CH_QUOTE || b == CH_BSLASH)
        begin
            owe(CH_BSLASH, 1'b0);
            owe(b, 1'b0);
        end
        else if (b == CH_NL)
        begin
            owe(CH_BSLASH, 1'b0);
            owe(CH_N, 1'b0);
        end
        else if (b == CH_CR)
        begin
            owe(CH_BSLASH, 1'b0);
            owe(CH_R, 1'b0);
        end
        else if (b == CH_TAB)
        begin
            owe(CH_BSLASH, 1'b0);
            owe(CH_T, 1'b0);
        end
        else if (b < CTRL_TOP)
            owe_u_escape(CH_0, CH_0, hex_char(b[7:4]), hex_char(b[3:0]));
        else
            owe(b, 1'b0);
    endtask

    // Release held prefix bytes unchanged.
    task automatic flush_held();
        if (held_n == HELD_E2 || held_n == HELD_E280)
            owe(LEAD_E2, 1'b0);
        if (held_n == HELD_E280)
            owe(MID_80, 1'b0);
        held_n = HELD_NONE;
    endtask

    // Advance the model by one accepted item and queue the bytes it owes.
    task automatic escape_item(input logic [7:0] b, input logic h, input logic e);
        if (h || e)
        begin
            if (!str_open)
            begin
                held_n = HELD_NONE;
                owe(CH_QUOTE, 1'b0);
                str_open = 1'b1;
            end
            if (h)
            begin
                case (held_n)
                    HELD_NONE: escape_fresh(b);
                    HELD_E2:
                    begin
                        if (b == MID_80)
                            held_n = HELD_E280;
                        else
                        begin
                            flush_held();
                            escape_fresh(b);
                        end
                    end
                    default:
                    begin
                        if (b == TAIL_A8)
                        begin
                            held_n = HELD_NONE;
                            owe_u_escape(CH_2, CH_0, CH_2, CH_8);
                        end
                        else if (b == TAIL_A9)
                        begin
                            held_n = HELD_NONE;
                            owe_u_escape(CH_2, CH_0, CH_2, CH_9);
                        end
                        else
                        begin
                            flush_held();
                            escape_fresh(b);
                        end
                    end
                endcase
            end
            if (e)
            begin
                flush_held();
                owe(CH_QUOTE, 1'b1);
                str_open = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one item and hold it until the transfer. Called at a rising
    // edge; returns at the edge of the transfer with in_valid still high.
    task automatic send_item(input logic [7:0] b, input logic h, input logic e,
                             input int n_typed, input logic [71:0] chars);
        int mark;
        int k;
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        has_byte      <= h;
        end_of_string <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Transfer happened at this edge: run the model now, so the owed
        // bytes are queued before the first of them can come out.
        mark = lit_due.size();
        escape_item(b, h, e);
        if (n_typed >= 0)
        begin
            // Typed row: replace the model's bytes with the table's.
            while (lit_due.size() > mark)
                void'(lit_due.pop_back());
            for (k = 0; k < n_typed; k++)
                owe(chars[(n_typed - 1 - k) * 8 +: 8], e && (k == n_typed - 1));
        end
        if (h || e)
            items_done++;
    endtask

    // Drop valid and hold off until every owed byte has come out.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lit_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        int r;
        r = $urandom_range(99);
        if (r < 35)
            v = 8'($urandom_range(8'h7E, 8'h20));
        else if (r < 50)
        begin
            case ($urandom_range(4))
                0: v = CH_QUOTE;
                1: v = CH_BSLASH;
                2: v = CH_NL;
                3: v = CH_CR;
                default: v = CH_TAB;
            endcase
        end
        else if (r < 65)
            v = 8'($urandom_range(8'h1F, 8'h00));
        else if (r < 75)
            v = LEAD_E2;
        else if (r < 83)
            v = MID_80;
        else if (r < 90)
            v = $urandom_range(1) ? TAIL_A8 : TAIL_A9;
        else
            v = 8'($urandom_range(255));
        return v;
    endfunction

    // Build one string of random content and send it. Separator sequences
    // are planted whole most of the time, broken some of the time; the
    // string closes either on its last byte or with a bare end item.
    task automatic send_random_string();
        logic [7:0] body[$];
        int         len;
        int         r;
        logic       close_on_byte;
        len = $urandom_range(12);
        while (body.size() < len)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                body = {body, LEAD_E2};
                body = {body, MID_80};
                body = {body, (r < 6) ? TAIL_A8 : TAIL_A9};
            end
            else if (r < 20)
            begin
                body = {body, LEAD_E2};
                if (r < 16)
                    body = {body, MID_80};
            end
            else
                body = {body, pick_byte()};
        end
        close_on_byte = (body.size() != 0) && ($urandom_range(1) == 1);
        foreach (body[i])
        begin
            // Slip in a bare item now and then; it must change nothing.
            if ($urandom_range(99) < 4)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, -1, '0);
            send_item(body[i], 1'b1, close_on_byte && (i == body.size() - 1), -1, '0);
        end
        if (!close_on_byte)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1, -1, '0);
    endtask

    task automatic tab_row(input logic [7:0] b, input logic h, input logic e,
                           input int n_typed, input logic [71:0] chars);
        dir_row_t r;
        r.b       = b;
        r.h       = h;
        r.e       = e;
        r.n_typed = n_typed;
        r.chars   = chars;
        dir_tab = {dir_tab, r};
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall out_ready at the rate of the current phase.
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rcv_idle);

    // ------------------------------------------------------------------
    // Checker: compare every output transfer with the oldest owed byte.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (lit_due.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, got out_char %02h out_last %0b",
                         $time, out_char, out_last);
                fail_cnt++;
            end
            else
            begin
                head = lit_due.pop_front();
                if (out_char !== head.ch)
                begin
                    $display("%0t: out_char mismatch: expected %02h, got %02h",
                             $time, head.ch, out_char);
                    fail_cnt++;
                end
                if (out_last !== head.last)
                begin
                    $display("%0t: out_last mismatch: expected %0b, got %0b",
                             $time, head.last, out_last);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog: no transfer for %0d cycles, %0d bytes owed",
                         $time, quiet_cycles, lit_due.size());
                $display("js_string_literal_escaper regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int ph;
        int target;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        has_byte      = 1'b0;
        end_of_string = 1'b0;
        out_ready     = 1'b0;
        held_n        = HELD_NONE;
        str_open      = 1'b0;
        fail_cnt      = 0;
        items_done    = 0;
        quiet_cycles  = 0;
        snd_idle      = 0;
        rcv_idle      = 0;

        // Directed table. Typed rows: opening quote after reset, byte
        // extremes, every fixed escape, the 0x20 boundary, the empty
        // string and a bare item. Model rows: the separator sequences,
        // a bare item while two bytes are held, mismatch after E2 and
        // after E2 80, and a held E2 flushed at the end.
        tab_row(8'h41,     1'b1, 1'b0, 2, 72'({CH_QUOTE, 8'h41}));
        tab_row(8'h00,     1'b1, 1'b0, 6, 72'({CH_BSLASH, CH_U, CH_0, CH_0, CH_0, CH_0}));
        tab_row(8'hFF,     1'b1, 1'b0, 1, 72'({8'hFF}));
        tab_row(8'h1F,     1'b1, 1'b0, 6, 72'({CH_BSLASH, CH_U, CH_0, CH_0, 8'h31, 8'h46}));
        tab_row(CH_QUOTE,  1'b1, 1'b0, 2, 72'({CH_BSLASH, CH_QUOTE}));
        tab_row(CH_BSLASH, 1'b1, 1'b0, 2, 72'({CH_BSLASH, CH_BSLASH}));
        tab_row(CH_NL,     1'b1, 1'b0, 2, 72'({CH_BSLASH, CH_N}));
        tab_row(CH_CR,     1'b1, 1'b0, 2, 72'({CH_BSLASH, CH_R}));
        tab_row(CH_TAB,    1'b1, 1'b0, 2, 72'({CH_BSLASH, CH_T}));
        tab_row(CTRL_TOP,  1'b1, 1'b1, 2, 72'({CTRL_TOP, CH_QUOTE}));
        tab_row(LEAD_E2,   1'b0, 1'b1, 2, 72'({CH_QUOTE, CH_QUOTE}));
        tab_row(LEAD_E2,   1'b0, 1'b0, 0, '0);
        tab_row(LEAD_E2,   1'b1, 1'b0, -1, '0);
        tab_row(MID_80,    1'b1, 1'b0, -1, '0);
        tab_row(8'h00,     1'b0, 1'b0, -1, '0);
        tab_row(TAIL_A8,   1'b1, 1'b0, -1, '0);
        tab_row(LEAD_E2,   1'b1, 1'b0, -1, '0);
        tab_row(8'h7F,     1'b1, 1'b0, -1, '0);
        tab_row(LEAD_E2,   1'b1, 1'b0, -1, '0);
        tab_row(MID_80,    1'b1, 1'b0, -1, '0);
        tab_row(LEAD_E2,   1'b1, 1'b0, -1, '0);
        tab_row(MID_80,    1'b1, 1'b0, -1, '0);
        tab_row(TAIL_A9,   1'b1, 1'b1, -1, '0);
        tab_row(LEAD_E2,   1'b1, 1'b0, -1, '0);
        tab_row(8'h5A,     1'b0, 1'b1, -1, '0);

        // Hold reset low, then release it once.
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 0: sender idles 16%, receiver 51%.
        // Phase 1: the other way round. Phase 2: no idling on either side.
        for (ph = 0; ph < 3; ph++)
        begin
            snd_idle = (ph == 0) ? 16 : (ph == 1) ? 51 : 0;
            rcv_idle = (ph == 0) ? 51 : (ph == 1) ? 16 : 0;
            if (ph == 0)
            begin
                foreach (dir_tab[i])
                    send_item(dir_tab[i].b, dir_tab[i].h, dir_tab[i].e,
                              dir_tab[i].n_typed, dir_tab[i].chars);
            end
            // Let the block empty out completely at each phase change.
            wait_drain();
            target = items_done + ITEMS_PER_PHASE;
            while (items_done < target)
            begin
                if ($urandom_range(99) < 5)
                    wait_drain();
                send_random_string();
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_cnt == 0)
            $display("js_string_literal_escaper regression: pass");
        else
            $display("js_string_literal_escaper regression: fail");
        $finish;
    end

endmodule
